// ----- design/lkvc_pkg.sv -----
// lkvc_pkg: shared types and constants for the lru key-value cache
// request and result payloads, operation codes, lookup control struct
// no dependencies
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
    logic signed [KEY_W-1:0]   evicted_key;
  } out_t;

  // decisions taken by the lookup for one request
  typedef struct packed {
    logic hit;
    logic put_hit;
    logic insert;
    logic evict;
  } op_ctl_t;

endpackage

// ----- design/lru_key_value_cache.sv -----
// lru_key_value_cache: fully associative key-value cache, lru replacement
// request registered in req_r, result in out_data_r; one request per cycle
// while out_stall is low; rate set by the parallel tag compare and rank update
// synchronous active-low reset empties the store and sets capacity to 16
// cfg_ready is always high; depends on lkvc_pkg, lkvc_lookup, lkvc_store
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lkvc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkvc_pkg::out_t               out_data
);

  localparam int unsigned RW = $clog2(MAX_ENTRIES);
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);

  logic [lkvc_pkg::CAP_W-1:0]   cap_r;
  logic                         req_valid_r, req_valid_nxt;
  lkvc_pkg::in_t                req_r;
  logic                         out_valid_r, out_valid_nxt;
  lkvc_pkg::out_t               out_data_r;
  logic                         advance;
  logic                         in_xfer;

  lkvc_pkg::op_ctl_t            ctl;
  lkvc_pkg::out_t               result;
  logic [MAX_ENTRIES-1:0]       hit_oh, free_oh, old_oh;
  logic [RW-1:0]                hit_rank;
  logic [MAX_ENTRIES-1:0]       entry_valid;
  logic [lkvc_pkg::KEY_W-1:0]   entry_key   [MAX_ENTRIES];
  logic [lkvc_pkg::VALUE_W-1:0] entry_value [MAX_ENTRIES];
  logic [RW-1:0]                entry_rank  [MAX_ENTRIES];
  logic [OW-1:0]                occupancy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // request register moves on whenever the result register is free or drained
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_xfer) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  lkvc_lookup #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_lookup (
    .req         (req_r),
    .cap         (cap_r),
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .entry_rank  (entry_rank),
    .occupancy   (occupancy),
    .ctl         (ctl),
    .hit_oh      (hit_oh),
    .free_oh     (free_oh),
    .old_oh      (old_oh),
    .hit_rank    (hit_rank),
    .result      (result)
  );

  lkvc_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (advance),
    .req         (req_r),
    .ctl         (ctl),
    .hit_oh      (hit_oh),
    .free_oh     (free_oh),
    .old_oh      (old_oh),
    .hit_rank    (hit_rank),
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .entry_rank  (entry_rank),
    .occupancy   (occupancy)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/lkvc_lookup.sv -----
// lkvc_lookup: parallel tag compare, oldest-entry and free-slot selection
// produces the control struct, one-hot slot vectors and the result item
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_lookup #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  lkvc_pkg::in_t                        req,
  input  logic [lkvc_pkg::CAP_W-1:0]           cap,
  input  logic [MAX_ENTRIES-1:0]               entry_valid,
  input  logic [lkvc_pkg::KEY_W-1:0]           entry_key   [MAX_ENTRIES],
  input  logic [lkvc_pkg::VALUE_W-1:0]         entry_value [MAX_ENTRIES],
  input  logic [$clog2(MAX_ENTRIES)-1:0]       entry_rank  [MAX_ENTRIES],
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     occupancy,
  output lkvc_pkg::op_ctl_t                    ctl,
  output logic [MAX_ENTRIES-1:0]               hit_oh,
  output logic [MAX_ENTRIES-1:0]               free_oh,
  output logic [MAX_ENTRIES-1:0]               old_oh,
  output logic [$clog2(MAX_ENTRIES)-1:0]       hit_rank,
  output lkvc_pkg::out_t                       result
);

  localparam int unsigned RW = $clog2(MAX_ENTRIES);
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = ((OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W) + 1;

  logic [CW-1:0]               cap_ext;
  logic [CW-1:0]               cap_eff;
  logic                        full;
  logic [OW-1:0]               oldest_rank;
  logic [MAX_ENTRIES-1:0]      free_vec;
  logic [MAX_ENTRIES-1:0]      sel_oh;
  logic [lkvc_pkg::KEY_W-1:0]  sel_key;
  logic [lkvc_pkg::VALUE_W-1:0] sel_value;

  always_comb begin
    cap_ext = CW'(cap);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    full = CW'(occupancy) >= cap_eff;
  end

  // ranks form a permutation of 0..occupancy-1, so the oldest holds occupancy-1
  assign oldest_rank = occupancy - OW'(1);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_oh[i] = entry_valid[i] && (entry_key[i] == req.key);
      old_oh[i] = entry_valid[i] && (OW'(entry_rank[i]) == oldest_rank);
    end
  end

  always_comb begin
    ctl.hit     = |hit_oh;
    ctl.put_hit = ctl.hit && (req.func == lkvc_pkg::FUNC_PUT);
    ctl.insert  = !ctl.hit && (req.func == lkvc_pkg::FUNC_PUT);
    ctl.evict   = ctl.insert && full;
  end

  // evicted slot counts as free before the lowest free slot is picked
  assign free_vec = ~entry_valid | (ctl.evict ? old_oh : '0);
  assign free_oh  = free_vec & (~free_vec + MAX_ENTRIES'(1));

  // hit and eviction never coincide, so one read select serves both
  assign sel_oh = ctl.hit ? hit_oh : old_oh;

  always_comb begin
    sel_key   = '0;
    sel_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_key   = sel_key   | (entry_key[i]   & {lkvc_pkg::KEY_W{sel_oh[i]}});
      sel_value = sel_value | (entry_value[i] & {lkvc_pkg::VALUE_W{sel_oh[i]}});
      hit_rank  = hit_rank  | (entry_rank[i]  & {RW{hit_oh[i]}});
    end
  end

  always_comb begin
    result.hit         = ctl.hit;
    result.read_value  = (ctl.hit && (req.func == lkvc_pkg::FUNC_GET)) ? sel_value : '0;
    result.evicted     = ctl.evict;
    result.evicted_key = ctl.evict ? sel_key : '0;
  end

endmodule

// ----- design/lkvc_store.sv -----
// lkvc_store: entry registers (valid, key, value, recency rank) and occupancy
// applies the lookup decisions for one request per cycle while upd is high
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_store #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 upd,
  input  lkvc_pkg::in_t                        req,
  input  lkvc_pkg::op_ctl_t                    ctl,
  input  logic [MAX_ENTRIES-1:0]               hit_oh,
  input  logic [MAX_ENTRIES-1:0]               free_oh,
  input  logic [MAX_ENTRIES-1:0]               old_oh,
  input  logic [$clog2(MAX_ENTRIES)-1:0]       hit_rank,
  output logic [MAX_ENTRIES-1:0]               entry_valid,
  output logic [lkvc_pkg::KEY_W-1:0]           entry_key   [MAX_ENTRIES],
  output logic [lkvc_pkg::VALUE_W-1:0]         entry_value [MAX_ENTRIES],
  output logic [$clog2(MAX_ENTRIES)-1:0]       entry_rank  [MAX_ENTRIES],
  output logic [$clog2(MAX_ENTRIES+1)-1:0]     occupancy
);

  localparam int unsigned RW = $clog2(MAX_ENTRIES);
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);

  logic [MAX_ENTRIES-1:0]       valid_r, valid_nxt;
  logic [RW-1:0]                rank_r   [MAX_ENTRIES];
  logic [RW-1:0]                rank_nxt [MAX_ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]   key_r    [MAX_ENTRIES];
  logic [lkvc_pkg::VALUE_W-1:0] value_r  [MAX_ENTRIES];
  logic [OW-1:0]                occ_r, occ_nxt;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (ctl.hit) begin
        if (hit_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end else if (ctl.insert) begin
        if (free_oh[i]) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end else if (ctl.evict && old_oh[i]) begin
          valid_nxt[i] = 1'b0;
          rank_nxt[i]  = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end
    end
    occ_nxt = occ_r;
    if (ctl.insert && !ctl.evict) begin
      occ_nxt = occ_r + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (upd) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload storage, only read while the entry is valid
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (upd && ctl.insert && free_oh[i]) begin
        key_r[i]   <= req.key;
        value_r[i] <= req.value;
      end else if (upd && ctl.put_hit && hit_oh[i]) begin
        value_r[i] <= req.value;
      end
    end
  end

  assign entry_valid = valid_r;
  assign entry_key   = key_r;
  assign entry_value = value_r;
  assign entry_rank  = rank_r;
  assign occupancy   = occ_r;

endmodule

// ----- sim/lkvc_checker.sv -----
// lkvc_checker: watches the request, result and capacity channels of the lru cache,
// keeps its own copy of the store and checks every result against it in order
// depends on lkvc_pkg
`timescale 1ns / 1ps

module lkvc_checker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lkvc_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lkvc_pkg::out_t             out_data,
  output int                         fail_count,
  output int                         pending
);

  logic [SLOTS-1:0]             slot_valid;
  logic [lkvc_pkg::KEY_W-1:0]   slot_key   [SLOTS];
  logic [lkvc_pkg::VALUE_W-1:0] slot_value [SLOTS];
  int unsigned                  slot_rank  [SLOTS];
  int unsigned                  fill;
  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  lkvc_pkg::out_t               awaited [$];
  int                           mismatches = 0;

  assign fail_count = mismatches;

  task automatic flag(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t lkvc_checker: %s expected %h got %h", $time, what, want_v, got_v);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      flag(what, want_v, got_v);
    end
  endtask

  // one lookup against the store, updating contents and ranks as the cache does
  task automatic lookup_and_update(input lkvc_pkg::in_t req, output lkvc_pkg::out_t res);
    int unsigned limit;
    int unsigned aged;
    int          found;
    int          oldest;
    int          free_slot;
    int          i;
    res = '0;
    found = -1;
    oldest = -1;
    free_slot = -1;
    // 0 behaves as 1, anything above the store size as the store size
    if (capacity == 0) begin
      limit = 1;
    end else if (capacity > SLOTS) begin
      limit = SLOTS;
    end else begin
      limit = capacity;
    end
    for (i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == req.key) begin
        found = i;
      end
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (req.func == lkvc_pkg::FUNC_GET) begin
        res.read_value = slot_value[found];
      end else begin
        slot_value[found] = req.value;
      end
      aged = slot_rank[found];
      for (i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_rank[i] < aged) begin
          slot_rank[i]++;
        end
      end
      slot_rank[found] = 0;
    end else if (req.func == lkvc_pkg::FUNC_PUT) begin
      // only one eviction per put, even when capacity was lowered below the fill
      if (fill + 1 > limit) begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) begin
            oldest = i;
          end
        end
        if (oldest >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = slot_key[oldest];
          slot_valid[oldest] = 1'b0;
          slot_rank[oldest] = 0;
          fill--;
        end
      end
      for (i = 0; i < SLOTS; i++) begin
        if (free_slot < 0 && !slot_valid[i]) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) begin
            slot_rank[i]++;
          end
        end
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = req.key;
        slot_value[free_slot] = req.value;
        slot_rank[free_slot] = 0;
        fill++;
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    lkvc_pkg::out_t want;
    lkvc_pkg::out_t predicted;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i] = 0;
      end
      fill = 0;
      capacity = lkvc_pkg::CAP_RESET;
      awaited.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      // pop before push: a result never belongs to a request taken at the same edge
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          flag("result transfer with no request outstanding, read_value", '0,
               out_data.read_value);
        end else begin
          want = awaited.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("evicted", want.evicted, out_data.evicted);
          check_field("evicted_key", want.evicted_key, out_data.evicted_key);
        end
      end
      if (in_valid && !in_stall) begin
        lookup_and_update(in_data, predicted);
        awaited.push_back(predicted);
      end
      pending <= awaited.size();
    end
  end

endmodule

// ----- sim/lru_key_value_cache_tb.sv -----
// lru_key_value_cache_tb: drives requests and capacity writes into the lru cache
// with random gaps and result stalls; the checker beside it does the comparing
// depends on lkvc_pkg, lkvc_checker and the cache rtl
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  localparam int unsigned LIMIT  = 200000;
  localparam int unsigned POOL   = 24;
  localparam int unsigned PHASES = 9;
  localparam int unsigned BURST  = 140;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0] cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  lkvc_pkg::in_t              in_data;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  lkvc_pkg::out_t             out_data;
  logic                       steady = 1'b0;
  int                         fail_count;
  int                         pending;
  int unsigned                cycle_count = 0;
  logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL];
  logic [lkvc_pkg::CAP_W-1:0] phase_caps [PHASES] = '{5'd16, 5'd31, 5'd2, 5'd17, 5'd1,
                                                      5'd7, 5'd0, 5'd16, 5'd4};

  lru_key_value_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lkvc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 14);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("** lru_key_value_cache: FAILED **");
      $finish;
    end
  end

  // valid stays high from one transfer to the next unless a gap is drawn
  task automatic send(input logic f, input logic [lkvc_pkg::KEY_W-1:0] k,
                      input logic [lkvc_pkg::VALUE_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {f, k, v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // pending is registered behind the checker's queue, hence the leading clock
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                eff;
    int unsigned                span;
    logic [lkvc_pkg::KEY_W-1:0] key;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    for (int i = 0; i < POOL; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, hits, misses and an update on an empty then part-filled store
    set_capacity(5'd16);
    send(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send(lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
    send(lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h1234_5678);
    send(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
    send(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send(lkvc_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);

    // capacity dropped below the fill: gets and put hits keep everything,
    // new keys shed one entry each
    set_capacity(5'd2);
    send(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h0000_0005);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0001);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0002);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0003, 32'h0000_0003);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0004, 32'h0000_0004);
    send(lkvc_pkg::FUNC_GET, 32'h0000_0003, 32'h0000_0000);

    // zero capacity behaves as one
    set_capacity(5'd0);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0005, 32'hA5A5_A5A5);
    send(lkvc_pkg::FUNC_PUT, 32'h0000_0006, 32'h5A5A_5A5A);
    send(lkvc_pkg::FUNC_GET, 32'h0000_0006, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      if (phase_caps[p] == 0) begin
        eff = 1;
      end else if (phase_caps[p] > 16) begin
        eff = 16;
      end else begin
        eff = phase_caps[p];
      end
      // key set a little wider than the capacity so hits and evictions both occur
      span = (eff + 4 < POOL) ? eff + 4 : POOL - 1;
      steady <= (p == 3);
      repeat (BURST) begin
        key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span)];
        send($urandom_range(0, 1) ? lkvc_pkg::FUNC_PUT : lkvc_pkg::FUNC_GET, key, $urandom);
      end
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** lru_key_value_cache: PASSED **");
    end else begin
      $display("** lru_key_value_cache: FAILED **");
    end
    $finish;
  end

endmodule
